### rtl/dlsf_pkg.sv
package dlsf_pkg;

  localparam int MAX_INPUTS    = 16;
  localparam int MAX_OUTPUTS   = 16;
  localparam int TABLE_ENTRIES = 256;

  localparam int IDX_W     = $clog2(MAX_INPUTS);
  localparam int ROW_W     = $clog2(MAX_OUTPUTS);
  localparam int ADDR_W    = ROW_W + IDX_W;
  localparam int COUNT_W   = 5;
  localparam int DATA_W    = 16;
  localparam int FRAC_W    = 8;
  localparam int ACT_OUT_W = 9;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + IDX_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam int TAB_IDX_W = $clog2(TABLE_ENTRIES);
  localparam int LIM_W     = 3 + 2 * FRAC_W + 1;
  localparam int TAB_SHIFT = LIM_W - TAB_IDX_W;

  localparam logic signed [ACC_W-1:0] SIG_LIM = ACC_W'(8 << (2 * FRAC_W));
  localparam logic [ACT_OUT_W-1:0]    SIG_ONE = ACT_OUT_W'(1 << FRAC_W);

  localparam logic [63:0] ONE_Q32      = 64'h0000_0001_0000_0000;
  localparam logic [63:0] EXP_M1_Q32   = 64'd1580030169;

  typedef enum logic {
    OP_WEIGHT = 1'b0,
    OP_ACT    = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_COUNT  = 1'b0,
    CFG_OUTPUT_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             wt_we;
    logic             act_we;
    logic             issue;
    logic [ROW_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             acc_clr;
    logic             emit;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

  typedef logic [ACT_OUT_W-1:0] sig_table_t [TABLE_ENTRIES];

  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] exp_neg_q32(input logic [63:0] t);
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    whole = t >> 32;
    frac  = {32'd0, t[31:0]};
    term  = ONE_Q32;
    pos   = ONE_Q32;
    neg   = '0;
    for (int k = 1; k <= 20; k++) begin
      term = long_div((term * frac) >> 32, 64'(k));
      if ((k % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    r = pos - neg;
    for (int k = 0; k < 8; k++) begin
      if (64'(k) < whole) begin
        r = (r * EXP_M1_Q32) >> 32;
      end
    end
    return r;
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t  tab;
    logic [63:0] a;
    logic [63:0] h;
    logic [63:0] mag;
    logic [63:0] t;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] q;
    logic        nonneg;
    h = 64'(8 * TABLE_ENTRIES);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      a      = 64'(16 * i);
      nonneg = a >= h;
      mag    = nonneg ? a - h : h - a;
      t      = (mag << 32) >> TAB_IDX_W;
      e      = exp_neg_q32(t);
      d      = ONE_Q32 + e;
      num    = nonneg ? (ONE_Q32 << 9) : (e << 9);
      q      = long_div(num + d, d << 1);
      tab[i] = q[ACT_OUT_W-1:0];
    end
    return tab;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

### rtl/dlsf_ctrl.sv
module dlsf_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic                            last_input,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dlsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlsf_pkg::COUNT_W-1:0]    cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dlsf_pkg::dp_cmd_t               cmd,
  input  dlsf_pkg::dp_status_t            status
);
  import dlsf_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [ROW_W-1:0]   row;
  logic [ROW_W-1:0]   row_next;
  logic [IDX_W-1:0]   col;
  logic [IDX_W-1:0]   col_next;
  logic [COUNT_W-1:0] input_count;
  logic [COUNT_W-1:0] output_count;
  logic [IDX_W-1:0]   in_last;
  logic [ROW_W-1:0]   out_last;
  logic               in_fire;
  logic               start;
  logic               emit_ok;
  logic               last_col;
  logic               last_row;

  always_comb begin
    if (input_count == '0) begin
      in_last = '0;
    end else if (input_count > COUNT_W'(MAX_INPUTS)) begin
      in_last = IDX_W'(MAX_INPUTS - 1);
    end else begin
      in_last = IDX_W'(input_count - 1'b1);
    end
    if (output_count == '0) begin
      out_last = '0;
    end else if (output_count > COUNT_W'(MAX_OUTPUTS)) begin
      out_last = ROW_W'(MAX_OUTPUTS - 1);
    end else begin
      out_last = ROW_W'(output_count - 1'b1);
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign start     = in_fire && (op == OP_ACT) && last_input;
  assign emit_ok   = !out_valid || out_ready;
  assign last_col  = (col == in_last);
  assign last_row  = (row == out_last);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_RUN;
      ST_RUN:   if (last_col) state_next = ST_DRAIN;
      ST_DRAIN: if (!status.pipe_busy) state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_ok) state_next = last_row ? ST_IDLE : ST_RUN;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.row = row;
    cmd.col = col;
    cmd.last = last_row;
    unique case (state)
      ST_IDLE: begin
        cmd.wt_we   = in_fire && (op == OP_WEIGHT);
        cmd.act_we  = in_fire && (op == OP_ACT);
        cmd.acc_clr = 1'b1;
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd.issue = 1'b0;
      end
      ST_EMIT: begin
        cmd.emit    = emit_ok;
        cmd.acc_clr = emit_ok;
      end
      default: begin
        cmd.issue = 1'b0;
      end
    endcase
  end

  always_comb begin
    row_next = row;
    col_next = col;
    unique case (state)
      ST_IDLE: begin
        row_next = '0;
        col_next = '0;
      end
      ST_RUN: begin
        if (!last_col) col_next = col + 1'b1;
      end
      ST_DRAIN: begin
        col_next = '0;
      end
      ST_EMIT: begin
        if (emit_ok && !last_row) row_next = row + 1'b1;
      end
      default: begin
        col_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      row          <= '0;
      col          <= '0;
      out_valid    <= 1'b0;
      input_count  <= COUNT_W'(MAX_INPUTS);
      output_count <= COUNT_W'(MAX_OUTPUTS);
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_INPUT_COUNT:  input_count  <= cfg_data;
          CFG_OUTPUT_COUNT: output_count <= cfg_data;
          default:          input_count  <= input_count;
        endcase
      end
    end
  end

endmodule

### rtl/dlsf_datapath.sv
module dlsf_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [dlsf_pkg::ROW_W-1:0]            neuron_index,
  input  logic [dlsf_pkg::IDX_W-1:0]            input_index,
  input  logic signed [dlsf_pkg::DATA_W-1:0]    value,
  input  dlsf_pkg::dp_cmd_t                     cmd,
  output dlsf_pkg::dp_status_t                  status,
  output logic [dlsf_pkg::ROW_W-1:0]            neuron_out,
  output logic [dlsf_pkg::ACT_OUT_W-1:0]        activation_out,
  output logic                                  last_result
);
  import dlsf_pkg::*;

  logic signed [DATA_W-1:0] wt_mem [MAX_OUTPUTS * MAX_INPUTS];
  logic signed [DATA_W-1:0] act_buf [MAX_INPUTS];
  logic signed [DATA_W-1:0] wt_q;
  logic signed [DATA_W-1:0] act_q;
  logic signed [PROD_W-1:0] mult;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;
  logic [TAB_IDX_W-1:0]     tab_idx;
  logic [ACT_OUT_W-1:0]     sig;
  logic                     rd_valid;
  logic                     mul_valid;

  always_ff @(posedge clk) begin
    if (cmd.wt_we) begin
      wt_mem[{neuron_index, input_index}] <= value;
    end
    wt_q <= wt_mem[{cmd.row, cmd.col}];
  end

  always_ff @(posedge clk) begin
    if (cmd.act_we) begin
      act_buf[input_index] <= value;
    end
    act_q <= act_buf[cmd.col];
  end

  assign mult = wt_q * act_q;

  always_ff @(posedge clk) begin
    prod <= mult;
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (mul_valid) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
    end else begin
      rd_valid  <= cmd.issue;
      mul_valid <= rd_valid;
    end
  end

  assign status.pipe_busy = rd_valid || mul_valid;

  assign shifted = acc + SIG_LIM;
  assign tab_idx = shifted[TAB_SHIFT +: TAB_IDX_W];

  always_comb begin
    if (acc < -SIG_LIM) begin
      sig = '0;
    end else if (acc >= SIG_LIM) begin
      sig = SIG_ONE;
    end else begin
      sig = SIG_TABLE[tab_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      neuron_out     <= cmd.row;
      activation_out <= sig;
      last_result    <= cmd.last;
    end
  end

endmodule

### rtl/dense_layer_sigmoid_forward.sv
// Fully connected layer with sigmoid output on signed Q8.8 data. Send weights
// (op 0) addressed by neuron and input position, then activations (op 1); the
// activation word marked last starts the layer. For each neuron in turn one
// shared multiply-accumulate walks the weight row against the activation
// buffer, one weight a cycle from the weight memory, and a 256-entry sigmoid
// table over [-8,8) gives an unsigned Q1.8 result (256 is one, saturating
// outside the range). Neurons are computed one after another, paced by the
// single MAC walking the weight memory read port; the input channel is held
// off until the last result word is in the output register. Weights and
// activations must be written before they are used. Configuration
// registers: 0 input_count, 1 output_count (1..16, zero acts as one); write
// them only while the block is idle.
module dense_layer_sigmoid_forward (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic [dlsf_pkg::ROW_W-1:0]           neuron_index,
  input  logic [dlsf_pkg::IDX_W-1:0]           input_index,
  input  logic signed [dlsf_pkg::DATA_W-1:0]   value,
  input  logic                                 last_input,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dlsf_pkg::ROW_W-1:0]           neuron_out,
  output logic [dlsf_pkg::ACT_OUT_W-1:0]       activation_out,
  output logic                                 last_result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dlsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dlsf_pkg::COUNT_W-1:0]         cfg_data
);
  import dlsf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dlsf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .last_input (last_input),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .status     (status)
  );

  dlsf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .neuron_index   (neuron_index),
    .input_index    (input_index),
    .value          (value),
    .cmd            (cmd),
    .status         (status),
    .neuron_out     (neuron_out),
    .activation_out (activation_out),
    .last_result    (last_result)
  );

endmodule

### tb/sv/testbench.sv
module testbench;
  import dlsf_pkg::*;

  localparam logic [63:0] Q32_ONE      = 64'h0000_0001_0000_0000;
  localparam logic [63:0] INV_E_Q32    = 64'd1580030169;
  localparam logic signed [63:0] SQUASH_SPAN = 64'sd524288;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int RANDOM_ITEMS  = 48;
  localparam int LAYER_SPAN    = 8;

  typedef struct packed {
    logic [ROW_W-1:0]     neuron;
    logic [ACT_OUT_W-1:0] level;
    logic                 is_last;
  } result_t;

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE
  } ready_mode_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     op;
  logic [ROW_W-1:0]         neuron_index;
  logic [IDX_W-1:0]         input_index;
  logic signed [DATA_W-1:0] value;
  logic                     last_input;
  logic                     out_valid;
  logic                     out_ready;
  logic [ROW_W-1:0]         neuron_out;
  logic [ACT_OUT_W-1:0]     activation_out;
  logic                     last_result;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [COUNT_W-1:0]       cfg_data;

  logic signed [DATA_W-1:0] weight_mem [MAX_OUTPUTS][MAX_INPUTS];
  logic signed [DATA_W-1:0] act_mem [MAX_INPUTS];
  logic [ACT_OUT_W-1:0]     sigmoid_lut [TABLE_ENTRIES];
  logic [COUNT_W-1:0]       in_count_reg;
  logic [COUNT_W-1:0]       out_count_reg;
  result_t                  outputs_due [$];
  result_t                  head;

  int          error_count;
  int          items_sent;
  int          burst_left;
  int          stall_run;
  ready_mode_t stall_mode;

  dense_layer_sigmoid_forward dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .neuron_index   (neuron_index),
    .input_index    (input_index),
    .value          (value),
    .last_input     (last_input),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .neuron_out     (neuron_out),
    .activation_out (activation_out),
    .last_result    (last_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] exp_neg_fixed(input logic [63:0] t);
    logic [63:0] frac;
    logic [63:0] term;
    logic [63:0] sum_pos;
    logic [63:0] sum_neg;
    logic [63:0] res;
    int          whole;
    whole   = int'(t >> 32);
    frac    = t & 64'hFFFF_FFFF;
    term    = Q32_ONE;
    sum_pos = Q32_ONE;
    sum_neg = '0;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * frac) >> 32) / 64'(k);
      if ((k % 2) == 1) begin
        sum_neg = sum_neg + term;
      end else begin
        sum_pos = sum_pos + term;
      end
    end
    res = sum_pos - sum_neg;
    for (int k = 0; k < whole; k++) begin
      res = (res * INV_E_Q32) >> 32;
    end
    return res;
  endfunction

  function automatic void fill_sigmoid_lut();
    logic [63:0] pos;
    logic [63:0] mid;
    logic [63:0] mag;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] q;
    logic        upper;
    mid = 64'(8 * TABLE_ENTRIES);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      pos   = 64'(16 * i);
      upper = pos >= mid;
      mag   = upper ? pos - mid : mid - pos;
      e     = exp_neg_fixed((mag << 32) / 64'(TABLE_ENTRIES));
      d     = Q32_ONE + e;
      num   = upper ? (64'd512 * Q32_ONE) : (64'd512 * e);
      q     = (num + d) / (64'd2 * d);
      sigmoid_lut[i] = q[ACT_OUT_W-1:0];
    end
  endfunction

  function automatic logic [ACT_OUT_W-1:0] squash(input logic signed [63:0] acc);
    logic signed [63:0] offset;
    if (acc < -SQUASH_SPAN) return '0;
    if (acc >= SQUASH_SPAN) return ACT_OUT_W'(256);
    offset = acc + SQUASH_SPAN;
    return sigmoid_lut[offset[19:12]];
  endfunction

  function automatic int effective_count(input logic [COUNT_W-1:0] raw, input int cap);
    if (raw == 0) return 1;
    if (int'(raw) > cap) return cap;
    return int'(raw);
  endfunction

  function automatic void absorb_word(input op_t kind, input logic [ROW_W-1:0] row,
                                      input logic [IDX_W-1:0] col,
                                      input logic signed [DATA_W-1:0] v, input logic lst);
    logic signed [63:0] acc;
    result_t            r;
    int                 n_in;
    int                 n_out;
    if (kind == OP_WEIGHT) begin
      weight_mem[row][col] = v;
    end else begin
      act_mem[col] = v;
      if (lst) begin
        n_in  = effective_count(in_count_reg, MAX_INPUTS);
        n_out = effective_count(out_count_reg, MAX_OUTPUTS);
        for (int k = 0; k < n_out; k++) begin
          acc = '0;
          for (int j = 0; j < n_in; j++) begin
            acc = acc + weight_mem[k][j] * act_mem[j];
          end
          r.neuron  = ROW_W'(k);
          r.level   = squash(acc);
          r.is_last = (k == n_out - 1);
          outputs_due = {outputs_due, r};
        end
      end
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    int mag;
    if ($urandom_range(0, 3) == 0) return DATA_W'($urandom);
    mag = $urandom_range(0, 1 << $urandom_range(3, 9));
    return ($urandom_range(0, 1) != 0) ? DATA_W'(-mag) : DATA_W'(mag);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input int span);
    if ($urandom_range(0, 3) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, span - 1));
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COUNT_W'(1);
      2: return COUNT_W'(LAYER_SPAN);
      default: return COUNT_W'($urandom_range(1, LAYER_SPAN));
    endcase
  endfunction

  task automatic send_word(input op_t kind, input logic [ROW_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic signed [DATA_W-1:0] v,
                           input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    op           <= kind;
    neuron_index <= row;
    input_index  <= col;
    value        <= v;
    last_input   <= lst;
    do @(posedge clk); while (!in_ready);
    absorb_word(kind, row, col, v, lst);
    items_sent++;
  endtask

  // drop valid, drain every result word, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [COUNT_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (which == CFG_INPUT_COUNT) begin
      in_count_reg = data;
    end else begin
      out_count_reg = data;
    end
  endtask

  task automatic test_saturation();
    write_reg(CFG_INPUT_COUNT, COUNT_W'(1));
    write_reg(CFG_OUTPUT_COUNT, COUNT_W'(1));
    send_word(OP_WEIGHT, 4'd0, 4'd0, 16'sh7FFF, 1'b0);
    send_word(OP_ACT, 4'd15, 4'd0, 16'sh7FFF, 1'b1);
    send_word(OP_WEIGHT, 4'd0, 4'd0, 16'sh8000, 1'b0);
    send_word(OP_ACT, 4'd0, 4'd0, 16'sh7FFF, 1'b1);
    send_word(OP_ACT, 4'd0, 4'd0, 16'sh8000, 1'b1);
  endtask

  task automatic test_table_edges();
    send_word(OP_WEIGHT, 4'd0, 4'd0, 16'sh0800, 1'b0);
    send_word(OP_ACT, 4'd0, 4'd0, 16'sh0100, 1'b1);
    send_word(OP_WEIGHT, 4'd0, 4'd0, 16'shF800, 1'b0);
    send_word(OP_ACT, 4'd0, 4'd0, 16'sh0100, 1'b1);
    send_word(OP_WEIGHT, 4'd0, 4'd0, 16'sh0800, 1'b0);
    send_word(OP_ACT, 4'd0, 4'd0, 16'sh00FF, 1'b1);
    send_word(OP_ACT, 4'd0, 4'd0, 16'sh0000, 1'b1);
  endtask

  task automatic test_start_cases();
    send_word(OP_ACT, 4'd7, 4'd0, 16'sh0080, 1'b0);
    send_word(OP_ACT, 4'd3, 4'd5, rand_value(), 1'b1);
    send_word(OP_WEIGHT, 4'd0, 4'd0, 16'sh0100, 1'b1);
    send_word(OP_ACT, 4'd12, 4'd9, rand_value(), 1'b1);
  endtask

  task automatic test_count_codes();
    write_reg(CFG_INPUT_COUNT, COUNT_W'(0));
    write_reg(CFG_OUTPUT_COUNT, COUNT_W'(0));
    send_word(OP_ACT, 4'd1, 4'd3, rand_value(), 1'b1);
  endtask

  task automatic test_full_layer();
    write_reg(CFG_INPUT_COUNT, COUNT_W'(31));
    write_reg(CFG_OUTPUT_COUNT, COUNT_W'(1));
    for (int i = 0; i < MAX_INPUTS; i++) begin
      send_word(OP_WEIGHT, ROW_W'(0), IDX_W'(i), rand_value(), 1'b0);
    end
    for (int i = 0; i < MAX_INPUTS; i++) begin
      send_word(OP_ACT, ROW_W'($urandom), IDX_W'(i), rand_value(), i == MAX_INPUTS - 1);
    end
    write_reg(CFG_INPUT_COUNT, COUNT_W'(1));
    write_reg(CFG_OUTPUT_COUNT, COUNT_W'(17));
    for (int n = 1; n < MAX_OUTPUTS; n++) begin
      send_word(OP_WEIGHT, ROW_W'(n), IDX_W'(0), rand_value(), 1'b0);
    end
    send_word(OP_ACT, ROW_W'($urandom), IDX_W'(0), rand_value(), 1'b1);
  endtask

  task automatic random_layer();
    int n_in;
    int n_out;
    n_in  = effective_count(in_count_reg, MAX_INPUTS);
    n_out = effective_count(out_count_reg, MAX_OUTPUTS);
    repeat ($urandom_range(0, 6)) begin
      send_word(OP_WEIGHT, ROW_W'(pick_index(n_out)), pick_index(n_in), rand_value(),
                $urandom_range(0, 5) == 0);
    end
    repeat ($urandom_range(0, n_in)) begin
      send_word(OP_ACT, ROW_W'($urandom), pick_index(n_in), rand_value(), 1'b0);
    end
    send_word(OP_ACT, ROW_W'($urandom), pick_index(n_in), rand_value(), 1'b1);
  endtask

  task automatic test_random_layers();
    int start_count;
    for (int n = 1; n < LAYER_SPAN; n++) begin
      for (int i = 1; i < LAYER_SPAN; i++) begin
        send_word(OP_WEIGHT, ROW_W'(n), IDX_W'(i), rand_value(), 1'b0);
      end
    end
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      write_reg(CFG_INPUT_COUNT, pick_count());
      write_reg(CFG_OUTPUT_COUNT, pick_count());
      repeat ($urandom_range(1, 4)) random_layer();
    end
  endtask

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = ready_mode_t'($urandom_range(0, 2));
      stall_run  = $urandom_range(4, 40);
    end
    stall_run--;
    case (stall_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
      default:      out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (outputs_due.size() == 0) begin
        $error("unexpected result word: neuron_out %0d activation_out %0d",
               neuron_out, activation_out);
        error_count++;
      end else begin
        head = outputs_due.pop_front();
        if (neuron_out !== head.neuron) begin
          $error("neuron_out: expected %0d, got %0d", head.neuron, neuron_out);
          error_count++;
        end
        if (activation_out !== head.level) begin
          $error("activation_out: expected %0d, got %0d", head.level, activation_out);
          error_count++;
        end
        if (last_result !== head.is_last) begin
          $error("last_result: expected %0d, got %0d", head.is_last, last_result);
          error_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = OP_WEIGHT;
    neuron_index  = '0;
    input_index   = '0;
    value         = '0;
    last_input    = 1'b0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_INPUT_COUNT;
    cfg_data      = '0;
    in_count_reg  = COUNT_W'(16);
    out_count_reg = COUNT_W'(16);
    fill_sigmoid_lut();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_saturation();
    test_table_edges();
    test_start_cases();
    test_count_codes();
    test_full_layer();
    test_random_layers();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && outputs_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
